@@ rtl/core/cqt_pkg.sv @@
// Package for the comment/quote tokenizer: scan modes, result kinds, byte codes.
// Shared by the scanner, the output stage and the top level. No dependencies.
package cqt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_PLAIN   = 2'd2,
        MODE_QUOTED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOS  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LOW   = 8'h21;
    localparam logic [7:0] CH_HIGH  = 8'h7E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int unsigned CAP_W = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd64;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
        logic [7:0] char_index;
        logic [7:0] token_length;
    } result_t;

endpackage

@@ rtl/core/cqt_in_if.sv @@
// Input channel of the tokenizer: one byte or an end-of-stream mark per transfer.
// Standalone; no package needed.
interface cqt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

@@ rtl/core/cqt_out_if.sv @@
// Output channel of the tokenizer: one result item per transfer.
// Standalone; no package needed.
interface cqt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [7:0] char_index;
    logic [7:0] token_length;

    modport source (output valid, output kind, output char_out, output char_index,
                    output token_length, input ready);
    modport sink   (input valid, input kind, input char_out, input char_index,
                    input token_length, output ready);
endinterface

@@ rtl/core/cqt_scanner.sv @@
// Scanner: capacity register, scan mode and kept count, result of one byte.
// Depends on cqt_pkg.
module cqt_scanner
    import cqt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             stream_end,
    output logic             res_valid,
    output result_t          res
);

    logic [CAP_W-1:0] cap_reg;
    mode_t            mode_reg, mode_next;
    logic [7:0]       kept_reg, kept_next;
    logic [7:0]       limit;
    logic [CAP_W-1:0] cap_m1;
    logic             printable;
    logic             can_keep;

    assign cap_m1 = cap_reg - CAP_W'(1);

    // kept characters = capacity - 1, saturated to 255, zero at capacity zero
    always_comb
    begin
        if (cap_reg == '0)
            limit = 8'd0;
        else if (cap_m1[CAP_W-1])
            limit = 8'hFF;
        else
            limit = cap_m1[7:0];
    end

    assign printable = (data_byte >= CH_LOW) && (data_byte <= CH_HIGH);
    assign can_keep  = kept_reg < limit;

    always_comb
    begin
        mode_next = mode_reg;
        kept_next = kept_reg;
        if (accept)
        begin
            if (stream_end)
            begin
                mode_next = MODE_IDLE;
                kept_next = 8'd0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (data_byte == CH_HASH)
                            mode_next = MODE_COMMENT;
                        else if (printable)
                        begin
                            if (data_byte == CH_QUOTE)
                            begin
                                mode_next = MODE_QUOTED;
                                kept_next = 8'd0;
                            end
                            else
                            begin
                                mode_next = MODE_PLAIN;
                                kept_next = (limit != 8'd0) ? 8'd1 : 8'd0;
                            end
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (data_byte == CH_NL)
                            mode_next = MODE_IDLE;
                    end
                    MODE_PLAIN:
                    begin
                        if (data_byte == CH_HASH)
                        begin
                            mode_next = MODE_COMMENT;
                            kept_next = 8'd0;
                        end
                        else if (!printable)
                        begin
                            mode_next = MODE_IDLE;
                            kept_next = 8'd0;
                        end
                        else if (can_keep)
                            kept_next = kept_reg + 8'd1;
                    end
                    MODE_QUOTED:
                    begin
                        if (data_byte == CH_QUOTE)
                        begin
                            mode_next = MODE_IDLE;
                            kept_next = 8'd0;
                        end
                        else if (can_keep)
                            kept_next = kept_reg + 8'd1;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_valid = 1'b0;
        res       = '{kind: KIND_CHAR, char_out: 8'd0, char_index: 8'd0,
                      token_length: 8'd0};
        if (accept)
        begin
            if (stream_end)
            begin
                res_valid = 1'b1;
                if (mode_reg == MODE_PLAIN || mode_reg == MODE_QUOTED)
                begin
                    res.kind         = KIND_EOS;
                    res.token_length = kept_reg;
                end
                else
                    res.kind = KIND_NONE;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        // a plain token opens with its first character at index zero
                        if (printable && data_byte != CH_HASH && data_byte != CH_QUOTE
                            && limit != 8'd0)
                        begin
                            res_valid    = 1'b1;
                            res.char_out = data_byte;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        res_valid = 1'b0;
                    end
                    MODE_PLAIN:
                    begin
                        if (data_byte == CH_HASH || !printable)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_END;
                            res.token_length = kept_reg;
                        end
                        else if (can_keep)
                        begin
                            res_valid      = 1'b1;
                            res.char_out   = data_byte;
                            res.char_index = kept_reg;
                        end
                    end
                    MODE_QUOTED:
                    begin
                        if (data_byte == CH_QUOTE)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_END;
                            res.token_length = kept_reg;
                        end
                        else if (can_keep)
                        begin
                            res_valid      = 1'b1;
                            res.char_out   = data_byte;
                            res.char_index = kept_reg;
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            mode_reg <= MODE_IDLE;
            kept_reg <= 8'd0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            mode_reg <= mode_next;
            kept_reg <= kept_next;
        end
    end

endmodule

@@ rtl/core/cqt_out_stage.sv @@
// Output stage: result register plus skid register, so the input side can
// keep taking bytes while a result waits. Depends on cqt_pkg.
module cqt_out_stage
    import cqt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_res,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            // skid entry is older than anything pushed this cycle
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_res;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ rtl/core/comment_quote_tokenizer_top.sv @@
// Top level of the comment/quote tokenizer.
// Depends on cqt_pkg, cqt_in_if, cqt_out_if, cqt_scanner, cqt_out_stage.
//
// Usage:
//   in_ch  : one text byte per transfer, or an end-of-stream mark (stream_end).
//   out_ch : zero or one result per input byte: a token character with its
//            index, a token end with its length, or an end-of-stream report.
//   cfg_we / cfg_wdata : writes token_capacity (characters kept = value - 1,
//            saturated at 255); write only while the block is idle.
// Path: a result is registered in the output stage before it appears on out_ch.
// Throughput: one byte per cycle while in_ch.ready is high; scan mode and kept
//   count are registered from the accepted byte.
// Stall: results sit in a result register backed by one skid register;
//   in_ch.ready drops only while the skid register is occupied. The input
//   still takes a byte while the result register stalls, then waits until the
//   skid register drains after the receiver is ready again.
// Reset: capacity returns to 64, scanner goes idle between tokens, and both
//   result registers are emptied.
module comment_quote_tokenizer_top
    import cqt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    cqt_in_if.sink           in_ch,
    cqt_out_if.source        out_ch
);

    logic    accept;
    logic    can_push;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_ch.ready = can_push;
    assign accept      = in_ch.valid && can_push;

    cqt_scanner u_scanner (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .data_byte  (in_ch.data_byte),
        .stream_end (in_ch.stream_end),
        .res_valid  (res_valid),
        .res        (res)
    );

    cqt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .can_push  (can_push),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res)
    );

    assign out_ch.kind         = out_res.kind;
    assign out_ch.char_out     = out_res.char_out;
    assign out_ch.char_index   = out_res.char_index;
    assign out_ch.token_length = out_res.token_length;

endmodule
